// ===== rtl/rgbhsi_pkg.sv =====
// Package with shared widths, types and constants of the RGB to HSI converter.
`timescale 1ns / 1ps
package rgbhsi_pkg;

  localparam int unsigned Steps = 22;
  localparam int unsigned VecW = 36;
  localparam int unsigned AngW = 24;
  localparam int unsigned DivW = 14;

  localparam logic [15:0] HueGray = 16'd11520;
  localparam logic [15:0] HueFull = 16'd46080;
  localparam logic [15:0] HueHalf = 16'd23040;
  localparam logic [12:0] OneQ12 = 13'd4096;
  localparam logic [AngW-1:0] AngMax = 24'd5898240;
  localparam logic [AngW-1:0] AngQuarter = 24'd2949120;
  localparam logic [17:0] Sqrt3Q16 = 18'd113512;

  // Side data carried along the chain with each pixel.
  typedef struct packed {
    logic        gray;
    logic        black;
    logic        mirror;
    logic [12:0] inten;
  } side_t;

  // Stage payload of the angle chain.
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } vec_t;

  // Saturation divider state: remainder, divisor, quotient bits so far.
  typedef struct packed {
    logic [DivW+1:0] rem;
    logic [DivW-1:0] den;
    logic [DivW-1:0] quo;
  } div_t;

  function automatic logic [AngW-1:0] atan_step(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0: v = 24'd1474560;   5'd1: v = 24'd870484;  5'd2: v = 24'd459940;
      5'd3: v = 24'd233473;    5'd4: v = 24'd117189;  5'd5: v = 24'd58652;
      5'd6: v = 24'd29333;     5'd7: v = 24'd14667;   5'd8: v = 24'd7334;
      5'd9: v = 24'd3667;      5'd10: v = 24'd1833;   5'd11: v = 24'd917;
      5'd12: v = 24'd458;      5'd13: v = 24'd229;    5'd14: v = 24'd115;
      5'd15: v = 24'd57;       5'd16: v = 24'd29;     5'd17: v = 24'd14;
      5'd18: v = 24'd7;        5'd19: v = 24'd4;      5'd20: v = 24'd2;
      5'd21: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rgbhsi_cell.sv =====
// One pipeline cell: a rotation step of the angle chain and, in the first DivW cells, a bit of the saturation divide.
`timescale 1ns / 1ps
module rgbhsi_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                nbit_i,
  input  rgbhsi_pkg::vec_t    vec_i,
  input  rgbhsi_pkg::div_t    div_i,
  input  rgbhsi_pkg::side_t   side_i,
  output rgbhsi_pkg::vec_t    vec_o,
  output rgbhsi_pkg::div_t    div_o,
  output rgbhsi_pkg::side_t   side_o
);

  rgbhsi_pkg::vec_t  vec_d, vec_q;
  rgbhsi_pkg::div_t  div_d, div_q;
  rgbhsi_pkg::side_t side_q;
  logic signed [rgbhsi_pkg::VecW-1:0] dx, dy;
  logic signed [rgbhsi_pkg::AngW-1:0] t;
  logic [rgbhsi_pkg::DivW+1:0] trial;

  always_comb begin
    dx = vec_i.y >>> Idx;
    dy = vec_i.x >>> Idx;
    t = rgbhsi_pkg::atan_step(5'(Idx));
    if (vec_i.y > 0) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + t;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - t;
    end
    // Restoring division, one quotient bit per cell for the first DivW cells.
    // The next numerator bit is shifted into the remainder before the trial.
    div_d = div_i;
    if (Idx < rgbhsi_pkg::DivW) begin
      trial = {div_i.rem[rgbhsi_pkg::DivW:0], nbit_i};
      div_d.quo = {div_i.quo[rgbhsi_pkg::DivW-2:0], 1'b0};
      if (trial >= {2'b00, div_i.den}) begin
        div_d.rem = trial - {2'b00, div_i.den};
        div_d.quo[0] = 1'b1;
      end else begin
        div_d.rem = trial;
      end
    end else begin
      trial = div_i.rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
      div_q <= div_d;
      side_q <= side_i;
    end
  end

  assign vec_o = vec_q;
  assign div_o = div_q;
  assign side_o = side_q;

endmodule

// ===== rtl/rgb_to_hsi_converter_unit.sv =====
// Top level of the pipelined RGB to HSI color converter.
`timescale 1ns / 1ps
// The converter takes one 8-bit RGB pixel per request and returns hue (degrees
// times 128), saturation and intensity (Q12 fractions of one). It accepts a
// pixel every clock cycle. A pixel passes 24 registers: one front stage that
// forms the vector, the intensity and the divider operands, a row of 22
// identical cells that each perform one vectoring rotation, the first 14 of
// which also produce one quotient bit of the saturation divide, and the
// output register. The finishing stage between the last cell and the output
// register is combinational.
// The whole pipeline advances together and stalls only while the output
// register holds a result the sink has not taken, so the latency is set by
// the length of the cell row.
module rgb_to_hsi_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // hue [15:0], saturation [28:16],
                                        // intensity [41:29], zero [47:42]
);

  localparam int unsigned N = rgbhsi_pkg::Steps;

  logic en;
  logic [N:0] vld_q;
  logic out_vld_q;
  logic [47:0] out_q;

  // The pipeline moves whenever the output slot is free or being emptied.
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Front stage.
  logic [7:0] r, g, b, mn;
  logic [9:0] sum;
  logic signed [rgbhsi_pkg::VecW-1:0] x0, y0;
  logic [8:0] dgb;
  logic [25:0] ysc;
  rgbhsi_pkg::vec_t  vec0_d, vec0_q;
  rgbhsi_pkg::div_t  div0_d, div0_q;
  rgbhsi_pkg::side_t side0_d, side0_q;
  logic [22:0] inum;
  logic [47:0] iprod;

  always_comb begin
    r = s_axis_tdata_i[7:0];
    g = s_axis_tdata_i[15:8];
    b = s_axis_tdata_i[23:16];
    sum = 10'(r) + 10'(g) + 10'(b);
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dgb = (g >= b) ? 9'(g - b) : 9'(b - g);
    ysc = 26'(dgb[7:0] * rgbhsi_pkg::Sqrt3Q16);
    x0 = rgbhsi_pkg::VecW'(($signed({2'b00, r, 1'b0}) - $signed({3'b000, g})
         - $signed({3'b000, b}))) <<< 16;
    y0 = rgbhsi_pkg::VecW'(ysc);
    if (x0 < 0) begin
      vec0_d.x = y0;
      vec0_d.y = -x0;
      vec0_d.z = rgbhsi_pkg::AngQuarter;
    end else begin
      vec0_d.x = x0;
      vec0_d.y = y0;
      vec0_d.z = '0;
    end
    // Divide (8192*(sum-3min)+sum) by 2*sum: numerator < 2^14 * den.
    div0_d.den = 14'({sum, 1'b0});
    div0_d.rem = '0;
    div0_d.quo = '0;
    // Intensity: (8192*sum+765)/1530 via reciprocal 2^34/1530 rounded up.
    inum = 23'({sum, 13'd0}) + 23'd765;
    iprod = 48'(inum) * 48'd11228673;  // ceil(2^34/1530)
    side0_d.inten = 13'(iprod >> 34);
    side0_d.gray = (r == g) && (g == b);
    side0_d.black = (sum == '0);
    side0_d.mirror = b > g;
  end

  // The divider needs the numerator shifted in a bit per cell; it is held in
  // a side register along the row as the top bits of rem are seeded here.
  logic [27:0] snum;
  assign snum = 28'({sum - 10'(3 * mn), 13'd0}) + 28'(sum);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec0_q <= vec0_d;
      side0_q <= side0_d;
      div0_q.den <= div0_d.den;
      div0_q.quo <= '0;
      div0_q.rem <= 16'(snum >> 14);
    end
  end

  // Numerator low bits travel alongside the divider cells.
  logic [13:0] nlo_q [rgbhsi_pkg::DivW];
  always_ff @(posedge clk_i) begin
    if (en) nlo_q[0] <= snum[13:0];
  end

  rgbhsi_pkg::vec_t  vec_w  [N+1];
  rgbhsi_pkg::div_t  div_w  [N+1];
  rgbhsi_pkg::side_t side_w [N+1];

  assign vec_w[0] = vec0_q;
  assign div_w[0] = div0_q;
  assign side_w[0] = side0_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic nbit;
    // Bring the next numerator bit into the remainder before the trial.
    if (k < rgbhsi_pkg::DivW) begin : g_bit
      assign nbit = nlo_q[k][rgbhsi_pkg::DivW-1-k];
    end else begin : g_nobit
      assign nbit = 1'b0;
    end
    rgbhsi_cell #(.Idx(k)) u_cell (
      .clk_i (clk_i), .en_i (en), .nbit_i (nbit),
      .vec_i (vec_w[k]), .div_i (div_w[k]), .side_i (side_w[k]),
      .vec_o (vec_w[k+1]), .div_o (div_w[k+1]), .side_o (side_w[k+1])
    );
    if (k + 1 < rgbhsi_pkg::DivW) begin : g_nlo
      always_ff @(posedge clk_i) begin
        if (en) nlo_q[k+1] <= nlo_q[k];
      end
    end
  end

  // Finishing stage.
  logic signed [rgbhsi_pkg::AngW-1:0] zc;
  logic [rgbhsi_pkg::AngW:0] zr;
  logic [15:0] th, hue, sat;
  logic [47:0] res;
  always_comb begin
    zc = vec_w[N].z;
    if (zc < 0) zc = '0;
    if (zc > $signed(rgbhsi_pkg::AngMax)) zc = rgbhsi_pkg::AngMax;
    zr = (25'(zc) + 25'd128) >> 8;
    th = 16'(zr);
    if (th > rgbhsi_pkg::HueHalf) th = rgbhsi_pkg::HueHalf;
    hue = side_w[N].mirror ? (rgbhsi_pkg::HueFull - th) : th;
    sat = 16'(div_w[N].quo);
    if (side_w[N].gray) begin
      hue = rgbhsi_pkg::HueGray;
      sat = side_w[N].black ? 16'(rgbhsi_pkg::OneQ12) : '0;
    end
    res = {6'd0, side_w[N].inten, sat[12:0], hue};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[N-1:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_q;

  // A held result never changes while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(out_q))
    else $error("result changed while stalled");
  // Ready follows the output slot.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("not ready with empty output");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q[28:16] <= rgbhsi_pkg::OneQ12)
    else $error("saturation out of range");

endmodule
